/* rtl/escape_sequence_key_decoder_core_assert.svh */
// Assertion macros for the key decoder.
`ifndef ESCAPE_SEQUENCE_KEY_DECODER_CORE_ASSERT_SVH
`define ESCAPE_SEQUENCE_KEY_DECODER_CORE_ASSERT_SVH

`ifndef SYNTH
`define ESCKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("esckd assertion failed");
`define ESCKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("esckd assertion failed");
`else
`define ESCKD_ASSERT_NOW(lbl, ante, cons)
`define ESCKD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/esckd_pkg.sv */
`timescale 1ns / 1ps

package esckd_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] CSI_BYTE  = 8'h5B;
  localparam logic [7:0] SS3_BYTE  = 8'h4F;
  localparam logic [7:0] TILDE     = 8'h7E;
  localparam logic [7:0] MOUSE_M   = 8'h4D;
  localparam logic [7:0] BTN_IN    = 8'd32;
  localparam logic [7:0] BTN_OUT   = 8'd35;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_1   = 8'h31;
  localparam logic [7:0] DIGIT_3   = 8'h33;
  localparam logic [7:0] DIGIT_4   = 8'h34;
  localparam logic [7:0] DIGIT_5   = 8'h35;
  localparam logic [7:0] DIGIT_6   = 8'h36;
  localparam logic [7:0] DIGIT_7   = 8'h37;
  localparam logic [7:0] DIGIT_8   = 8'h38;
  localparam logic [7:0] DIGIT_9   = 8'h39;

  localparam logic [3:0] KIND_CHAR  = 4'd0;
  localparam logic [3:0] KIND_ESC   = 4'd1;
  localparam logic [3:0] KIND_UP    = 4'd2;
  localparam logic [3:0] KIND_DOWN  = 4'd3;
  localparam logic [3:0] KIND_RIGHT = 4'd4;
  localparam logic [3:0] KIND_LEFT  = 4'd5;
  localparam logic [3:0] KIND_HOME  = 4'd6;
  localparam logic [3:0] KIND_END   = 4'd7;
  localparam logic [3:0] KIND_PGUP  = 4'd8;
  localparam logic [3:0] KIND_PGDN  = 4'd9;
  localparam logic [3:0] KIND_DEL   = 4'd10;
  localparam logic [3:0] KIND_MIN   = 4'd11;
  localparam logic [3:0] KIND_MOUT  = 4'd12;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    logic [3:0] key_kind;
    logic [7:0] char_value;
  } key_t;

  typedef struct packed {
    logic emit;
    key_t key;
  } dec_t;

  function automatic logic [3:0] tilde_kind(input logic [7:0] digit);
    logic [3:0] k;
    unique case (digit)
      DIGIT_1: k = KIND_HOME;
      DIGIT_3: k = KIND_DEL;
      DIGIT_4: k = KIND_END;
      DIGIT_5: k = KIND_PGUP;
      DIGIT_6: k = KIND_PGDN;
      DIGIT_7: k = KIND_HOME;
      DIGIT_8: k = KIND_END;
      default: k = KIND_ESC;
    endcase
    return k;
  endfunction

endpackage

/* rtl/esckd_chan_if.sv */
`timescale 1ns / 1ps

interface esckd_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/escape_sequence_key_decoder_core.sv */
`timescale 1ns / 1ps
// Data path: input register, combinational parser, result register.
// Throughput: one input transaction per cycle while the result side keeps up.
// The input register and the result register each hold one transaction.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to idle with the held byte cleared.

`include "escape_sequence_key_decoder_core_assert.svh"

module escape_sequence_key_decoder_core (
  input logic          clk,
  input logic          rst_n,
  esckd_chan_if.sink   in_chan,
  esckd_chan_if.source out_chan
);

  logic            in_valid;
  logic            in_ready;
  esckd_pkg::req_t in_payload;
  logic            out_valid;
  logic            out_ready;
  esckd_pkg::key_t out_key;
  logic            adv;
  logic            s1_valid;
  esckd_pkg::req_t s1_item;
  esckd_pkg::dec_t dec;

  assign in_valid         = in_chan.valid;
  assign in_payload       = in_chan.payload;
  assign in_chan.ready    = in_ready;
  assign out_ready        = out_chan.ready;
  assign out_chan.valid   = out_valid;
  assign out_chan.payload = out_key;

  esckd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_payload (in_payload),
    .in_ready   (in_ready),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  esckd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (s1_item),
    .dec   (dec)
  );

  esckd_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .dec       (dec),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_key   (out_key),
    .adv       (adv)
  );

  `ESCKD_ASSERT_NEXT(a_hold_on_stall, s1_valid && out_valid && !out_ready, s1_valid)
  `ESCKD_ASSERT_NOW(a_ready_when_empty, !in_ready, s1_valid)
  `ESCKD_ASSERT_NOW(a_char_zero, out_valid && (out_key.key_kind != esckd_pkg::KIND_CHAR), out_key.char_value == 8'd0)
  `ESCKD_ASSERT_NOW(a_kind_range, out_valid, out_key.key_kind <= esckd_pkg::KIND_MOUT)

endmodule

/* rtl/esckd_in_stage.sv */
`timescale 1ns / 1ps

module esckd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  esckd_pkg::req_t   in_payload,
  output logic              in_ready,
  input  logic              adv,
  output logic              s1_valid,
  output esckd_pkg::req_t   s1_item
);

  logic            valid_r;
  logic            valid_nxt;
  esckd_pkg::req_t item_r;
  logic            accept;

  assign in_ready = !valid_r || adv;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_payload;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

/* rtl/esckd_parser.sv */
`timescale 1ns / 1ps

module esckd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  esckd_pkg::req_t   item,
  output esckd_pkg::dec_t   dec
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_FIRST = 3'd2;
  localparam logic [2:0] PH_DIGIT = 3'd3;
  localparam logic [2:0] PH_M1    = 3'd4;
  localparam logic [2:0] PH_M2    = 3'd5;
  localparam logic [2:0] PH_M3    = 3'd6;

  logic [2:0] phase_r;
  logic [2:0] phase_nxt;
  logic [7:0] held_r;
  logic [7:0] held_nxt;
  logic       tick;
  logic [7:0] b;
  logic       is_digit;

  assign tick     = item.req_type;
  assign b        = item.byte_in;
  assign is_digit = (b >= esckd_pkg::DIGIT_0) && (b <= esckd_pkg::DIGIT_9);

  always_comb begin
    phase_nxt            = phase_r;
    held_nxt             = held_r;
    dec.emit             = 1'b0;
    dec.key.key_kind     = esckd_pkg::KIND_ESC;
    dec.key.char_value   = 8'd0;
    unique case (phase_r)
      PH_ESC: begin
        held_nxt  = b;
        phase_nxt = PH_FIRST;
      end
      PH_FIRST: begin
        dec.emit = 1'b1;
        if (held_r == esckd_pkg::CSI_BYTE) begin
          if (is_digit) begin
            dec.emit  = 1'b0;
            held_nxt  = b;
            phase_nxt = PH_DIGIT;
          end else begin
            case (b)
              esckd_pkg::CH_A:    dec.key.key_kind = esckd_pkg::KIND_UP;
              esckd_pkg::CH_B:    dec.key.key_kind = esckd_pkg::KIND_DOWN;
              esckd_pkg::CH_C:    dec.key.key_kind = esckd_pkg::KIND_RIGHT;
              esckd_pkg::CH_D:    dec.key.key_kind = esckd_pkg::KIND_LEFT;
              esckd_pkg::CH_H:    dec.key.key_kind = esckd_pkg::KIND_HOME;
              esckd_pkg::CH_F:    dec.key.key_kind = esckd_pkg::KIND_END;
              esckd_pkg::MOUSE_M: begin
                dec.emit  = 1'b0;
                phase_nxt = PH_M1;
              end
              default:            dec.key.key_kind = esckd_pkg::KIND_ESC;
            endcase
          end
        end else if (held_r == esckd_pkg::SS3_BYTE) begin
          if (b == esckd_pkg::CH_H) begin
            dec.key.key_kind = esckd_pkg::KIND_HOME;
          end else if (b == esckd_pkg::CH_F) begin
            dec.key.key_kind = esckd_pkg::KIND_END;
          end
        end
      end
      PH_DIGIT: begin
        dec.emit = 1'b1;
        if (b == esckd_pkg::TILDE) begin
          dec.key.key_kind = esckd_pkg::tilde_kind(held_r);
        end
      end
      PH_M1: begin
        held_nxt  = b;
        phase_nxt = PH_M2;
      end
      PH_M2: begin
        phase_nxt = PH_M3;
      end
      PH_M3: begin
        dec.emit = 1'b1;
        if (held_r == esckd_pkg::BTN_IN) begin
          dec.key.key_kind = esckd_pkg::KIND_MIN;
        end else if (held_r == esckd_pkg::BTN_OUT) begin
          dec.key.key_kind = esckd_pkg::KIND_MOUT;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (!tick) begin
          if (b == esckd_pkg::ESC_BYTE) begin
            phase_nxt = PH_ESC;
          end else begin
            dec.emit           = 1'b1;
            dec.key.key_kind   = esckd_pkg::KIND_CHAR;
            dec.key.char_value = b;
          end
        end
      end
    endcase

    // timeout inside a sequence: abandon the partial sequence, keep the held byte as it was and report a bare escape
    if (tick && (phase_r != PH_IDLE) && (phase_r <= PH_M3)) begin
      dec.emit           = 1'b1;
      dec.key.key_kind   = esckd_pkg::KIND_ESC;
      dec.key.char_value = 8'd0;
      held_nxt           = held_r;
    end

    if (dec.emit) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

/* rtl/esckd_out_stage.sv */
`timescale 1ns / 1ps

module esckd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_valid,
  input  esckd_pkg::dec_t   dec,
  input  logic              out_ready,
  output logic              out_valid,
  output esckd_pkg::key_t   out_key,
  output logic              adv
);

  logic            valid_r;
  logic            valid_nxt;
  esckd_pkg::key_t key_r;
  logic            load;

  assign adv  = s1_valid && (!valid_r || out_ready);
  assign load = adv && dec.emit;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= dec.key;
    end
  end

  assign out_valid = valid_r;
  assign out_key   = key_r;

endmodule

/* tb/escape_sequence_key_decoder_core_tb.sv */
`timescale 1ns / 1ps

module escape_sequence_key_decoder_core_tb;
  import esckd_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned ITEM_TARGET     = 900;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam logic [7:0]  FINAL_BYTES [6] = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_AFTER_ESC = 4'd1,
    ST_FIRST     = 4'd2,
    ST_DIGIT     = 4'd3,
    ST_MOUSE_B   = 4'd4,
    ST_MOUSE_X   = 4'd5,
    ST_MOUSE_Y   = 4'd6
  } seq_state_e;

  class key_decode_board;
    seq_state_e  seq_state;
    logic [7:0]  saved_byte;
    key_t        expected_keys[$];
    int unsigned decoded_items;
    int unsigned errors;

    function new();
      seq_state     = ST_IDLE;
      saved_byte    = 8'h00;
      decoded_items = 0;
      errors        = 0;
    endfunction

    function int unsigned pending();
      return expected_keys.size();
    endfunction

    function void note_request(req_t r);
      logic [3:0] kind;
      bit         emits;
      key_t       k;
      emits = 1'b1;
      kind  = KIND_ESC;
      if (seq_state == ST_IDLE && r.req_type) begin
        return;
      end
      decoded_items++;
      if (seq_state == ST_IDLE) begin
        if (r.byte_in == ESC_BYTE) begin
          seq_state = ST_AFTER_ESC;
          emits     = 1'b0;
        end else begin
          kind = KIND_CHAR;
        end
      end else if (!r.req_type) begin
        case (seq_state)
          ST_AFTER_ESC: begin
            saved_byte = r.byte_in;
            seq_state  = ST_FIRST;
            emits      = 1'b0;
          end
          ST_FIRST: begin
            if (saved_byte == CSI_BYTE) begin
              if (r.byte_in >= DIGIT_0 && r.byte_in <= DIGIT_9) begin
                saved_byte = r.byte_in;
                seq_state  = ST_DIGIT;
                emits      = 1'b0;
              end else begin
                case (r.byte_in)
                  CH_A: kind = KIND_UP;
                  CH_B: kind = KIND_DOWN;
                  CH_C: kind = KIND_RIGHT;
                  CH_D: kind = KIND_LEFT;
                  CH_H: kind = KIND_HOME;
                  CH_F: kind = KIND_END;
                  MOUSE_M: begin
                    seq_state = ST_MOUSE_B;
                    emits     = 1'b0;
                  end
                  default: kind = KIND_ESC;
                endcase
              end
            end else if (saved_byte == SS3_BYTE && r.byte_in == CH_H) begin
              kind = KIND_HOME;
            end else if (saved_byte == SS3_BYTE && r.byte_in == CH_F) begin
              kind = KIND_END;
            end
          end
          ST_DIGIT: begin
            if (r.byte_in == TILDE) begin
              case (saved_byte)
                DIGIT_1, DIGIT_7: kind = KIND_HOME;
                DIGIT_3:          kind = KIND_DEL;
                DIGIT_4, DIGIT_8: kind = KIND_END;
                DIGIT_5:          kind = KIND_PGUP;
                DIGIT_6:          kind = KIND_PGDN;
                default:          kind = KIND_ESC;
              endcase
            end
          end
          ST_MOUSE_B: begin
            saved_byte = r.byte_in;
            seq_state  = ST_MOUSE_X;
            emits      = 1'b0;
          end
          ST_MOUSE_X: begin
            seq_state = ST_MOUSE_Y;
            emits     = 1'b0;
          end
          default: begin
            if (saved_byte == BTN_IN) kind = KIND_MIN;
            else if (saved_byte == BTN_OUT) kind = KIND_MOUT;
          end
        endcase
      end
      if (emits) begin
        seq_state    = ST_IDLE;
        k.key_kind   = kind;
        k.char_value = (kind == KIND_CHAR) ? r.byte_in : 8'h00;
        expected_keys.push_back(k);
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_key(key_t got);
      key_t want;
      if (expected_keys.size() == 0) begin
        report_mismatch($sformatf("unexpected key kind %0d char %02h",
                                  got.key_kind, got.char_value));
        return;
      end
      want = expected_keys.pop_front();
      if (got.key_kind !== want.key_kind)
        report_mismatch($sformatf("key kind %0d, want %0d", got.key_kind, want.key_kind));
      if (got.char_value !== want.char_value)
        report_mismatch($sformatf("char value %02h, want %02h",
                                  got.char_value, want.char_value));
    endtask

    task check_drained();
      if (expected_keys.size() != 0)
        report_mismatch($sformatf("%0d keys never arrived", expected_keys.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   steady_source;
  bit   steady_sink;
  bit   hold_off_req;
  int unsigned cycle_count;

  key_decode_board board = new();

  esckd_chan_if #(.payload_t(req_t)) in_if ();
  esckd_chan_if #(.payload_t(key_t)) out_if ();

  escape_sequence_key_decoder_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("escape_sequence_key_decoder_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) board.note_request(in_if.payload);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) board.check_key(out_if.payload);
    end
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_if.ready <= steady_sink || ($urandom_range(99) >= 12);
    end
  end

  function automatic req_t byte_req(logic [7:0] b);
    req_t r;
    r.req_type = 1'b0;
    r.byte_in  = b;
    return r;
  endfunction

  function automatic req_t tick_req();
    req_t r;
    r.req_type = 1'b1;
    r.byte_in  = 8'($urandom_range(255));
    return r;
  endfunction

  task automatic send_item(req_t r);
    if (!steady_source && $urandom_range(99) < 12) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= r;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_random_sequence();
    req_t        seq[$];
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(99);
    if (pick < 15) begin
      seq.push_back(byte_req(8'($urandom_range(255))));
    end else if (pick < 20) begin
      seq.push_back(tick_req());
    end else begin
      seq.push_back(byte_req(ESC_BYTE));
      if (pick < 35) begin
        seq.push_back(byte_req(CSI_BYTE));
        seq.push_back(byte_req(FINAL_BYTES[$urandom_range(5)]));
      end else if (pick < 55) begin
        seq.push_back(byte_req(CSI_BYTE));
        seq.push_back(byte_req(8'($urandom_range(DIGIT_0, DIGIT_9))));
        seq.push_back(byte_req(($urandom_range(9) != 0) ? TILDE : 8'($urandom_range(255))));
      end else if (pick < 70) begin
        seq.push_back(byte_req(CSI_BYTE));
        seq.push_back(byte_req(MOUSE_M));
        cut = $urandom_range(9);
        seq.push_back(byte_req((cut < 4) ? BTN_IN : (cut < 8) ? BTN_OUT :
                               8'($urandom_range(255))));
        seq.push_back(byte_req(8'($urandom_range(255))));
        seq.push_back(byte_req(8'($urandom_range(255))));
      end else if (pick < 80) begin
        seq.push_back(byte_req(SS3_BYTE));
        cut = $urandom_range(2);
        seq.push_back(byte_req((cut == 0) ? CH_H : (cut == 1) ? CH_F :
                               8'($urandom_range(255))));
      end else if (pick < 90) begin
        seq.push_back(byte_req(CSI_BYTE));
        seq.push_back(byte_req(8'($urandom_range(255))));
      end else begin
        seq.push_back(byte_req(8'($urandom_range(255))));
        seq.push_back(byte_req(8'($urandom_range(255))));
      end
    end
    // cut some sequences short with a timeout
    if (seq.size() > 1 && $urandom_range(99) < 8) begin
      cut = $urandom_range(1, seq.size() - 1);
      while (seq.size() > cut) void'(seq.pop_back());
      seq.push_back(tick_req());
    end
    foreach (seq[i]) send_item(seq[i]);
  endtask

  initial begin
    req_t directed[$];
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    rst_n         = 1'b0;
    steady_source = 1'b0;
    steady_sink   = 1'b0;
    hold_off_req  = 1'b0;
    cycle_count   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed = '{byte_req(8'h00), byte_req(8'hFF), tick_req(),
                 byte_req(ESC_BYTE), byte_req(CSI_BYTE), byte_req(CH_A),
                 byte_req(ESC_BYTE), byte_req(SS3_BYTE), byte_req(CH_F),
                 byte_req(ESC_BYTE), byte_req(CSI_BYTE), byte_req(DIGIT_3), byte_req(TILDE),
                 byte_req(ESC_BYTE), byte_req(CSI_BYTE), byte_req(MOUSE_M), byte_req(BTN_OUT),
                 byte_req(8'h21), byte_req(8'h21),
                 byte_req(ESC_BYTE), byte_req(CSI_BYTE), byte_req(DIGIT_9), byte_req(TILDE),
                 byte_req(ESC_BYTE), tick_req()};
    foreach (directed[i]) send_item(directed[i]);

    // full rate both ways, then hold the sink off so the pipeline backs up
    steady_source = 1'b1;
    steady_sink   = 1'b1;
    repeat (30) send_random_sequence();
    hold_off_req = 1'b1;
    repeat (25) send_random_sequence();

    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    steady_source = 1'b0;
    steady_sink   = 1'b0;
    while (board.decoded_items < ITEM_TARGET) send_random_sequence();

    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) begin
      $display("escape_sequence_key_decoder_core regression: pass");
    end else begin
      $display("escape_sequence_key_decoder_core regression: fail");
    end
    $finish;
  end

endmodule
